[rtl/bitmap_font_text_rasterizer_unit_assert.svh]
// Assertion macros for the text rasterizer.
`ifndef BITMAP_FONT_TEXT_RASTERIZER_UNIT_ASSERT_SVH
`define BITMAP_FONT_TEXT_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BFTR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define BFTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bftr_pkg.sv]
package bftr_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int CHAR_BITS      = 8;
    localparam int PIX_BITS       = 16;
    localparam int COLOR_BITS     = 24;
    localparam int OUT_TDATA_BITS = 2 * PIX_BITS + COLOR_BITS;
    localparam int CFG_ADDR_BITS  = 4;
    localparam int CFG_DATA_BITS  = 32;

    localparam int GLYPH_W     = 5;
    localparam int GLYPH_H     = 7;
    localparam int GLYPH_CELLS = GLYPH_W * GLYPH_H;
    localparam int ADV_X       = GLYPH_W + 2;
    localparam int ADV_Y       = GLYPH_H + 1;
    localparam int NUM_GLYPHS  = 38;
    localparam int CELL_BITS   = $clog2(GLYPH_CELLS);
    localparam int ROW_BITS    = $clog2(GLYPH_H);
    localparam int COL_BITS    = $clog2(GLYPH_W);
    localparam int SLOT_BITS   = $clog2(NUM_GLYPHS);

    localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_COLON   = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CHAR_PERIOD  = 8'h2E;

    localparam logic [SLOT_BITS-1:0] SLOT_DIGIT_BASE = 6'd26;
    localparam logic [SLOT_BITS-1:0] SLOT_COLON      = 6'd36;
    localparam logic [SLOT_BITS-1:0] SLOT_PERIOD     = 6'd37;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_NEWLINE,
        CMD_SKIP,
        CMD_LOAD,
        CMD_STEP,
        CMD_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic code_newline;
        logic code_glyph;
        logic cell_lit;
        logic cell_last;
        logic out_free;
    } dp_status_t;

    // rows top to bottom, bit 4 is the leftmost column
    localparam logic [GLYPH_W-1:0] FONT_ROM [NUM_GLYPHS][GLYPH_H] = '{
        '{5'h1F,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
        '{5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F},
        '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
        '{5'h1F,5'h10,5'h10,5'h1F,5'h10,5'h10,5'h1F},
        '{5'h1F,5'h10,5'h10,5'h1F,5'h10,5'h10,5'h10},
        '{5'h1F,5'h10,5'h10,5'h13,5'h11,5'h11,5'h1F},
        '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F},
        '{5'h1F,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
        '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
        '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
        '{5'h1F,5'h15,5'h15,5'h15,5'h15,5'h11,5'h11},
        '{5'h11,5'h19,5'h19,5'h15,5'h13,5'h13,5'h11},
        '{5'h1F,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1F},
        '{5'h1F,5'h11,5'h11,5'h1F,5'h10,5'h10,5'h10},
        '{5'h1F,5'h11,5'h11,5'h11,5'h11,5'h1E,5'h01},
        '{5'h1F,5'h11,5'h11,5'h1F,5'h14,5'h12,5'h11},
        '{5'h1F,5'h10,5'h10,5'h1F,5'h01,5'h01,5'h1F},
        '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
        '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1F},
        '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
        '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h1F},
        '{5'h11,5'h0A,5'h0A,5'h04,5'h0A,5'h0A,5'h11},
        '{5'h11,5'h11,5'h11,5'h1F,5'h04,5'h04,5'h04},
        '{5'h1F,5'h01,5'h02,5'h02,5'h04,5'h08,5'h1F},
        '{5'h1F,5'h19,5'h15,5'h15,5'h15,5'h13,5'h1F},
        '{5'h0C,5'h14,5'h04,5'h04,5'h04,5'h04,5'h1F},
        '{5'h0E,5'h11,5'h01,5'h02,5'h0C,5'h10,5'h1F},
        '{5'h1E,5'h01,5'h01,5'h06,5'h01,5'h01,5'h1E},
        '{5'h03,5'h09,5'h11,5'h1F,5'h01,5'h01,5'h01},
        '{5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E},
        '{5'h0F,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E},
        '{5'h1F,5'h01,5'h02,5'h02,5'h04,5'h08,5'h10},
        '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
        '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h1E},
        '{5'h04,5'h04,5'h04,5'h00,5'h04,5'h04,5'h04},
        '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h18,5'h18}
    };

    // {valid, slot}
    function automatic logic [SLOT_BITS:0] glyph_lookup(input logic [CHAR_BITS-1:0] code);
        logic [SLOT_BITS:0] res;
        res = '0;
        if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
            res = {1'b1, SLOT_BITS'(code - CHAR_UPPER_A)};
        end else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9) begin
            res = {1'b1, SLOT_DIGIT_BASE + SLOT_BITS'(code - CHAR_DIGIT_0)};
        end else if (code == CHAR_COLON) begin
            res = {1'b1, SLOT_COLON};
        end else if (code == CHAR_PERIOD) begin
            res = {1'b1, SLOT_PERIOD};
        end
        return res;
    endfunction

    // bit row*GLYPH_W+col set when that cell is lit
    function automatic logic [GLYPH_CELLS-1:0] glyph_bitmap(input logic [SLOT_BITS-1:0] slot);
        logic [GLYPH_CELLS-1:0] bm;
        bm = '0;
        if (slot < SLOT_BITS'(NUM_GLYPHS)) begin
            for (int r = 0; r < GLYPH_H; r++) begin
                for (int c = 0; c < GLYPH_W; c++) begin
                    bm[r * GLYPH_W + c] = FONT_ROM[slot][r][GLYPH_W - 1 - c];
                end
            end
        end
        return bm;
    endfunction

endpackage

[rtl/bftr_regs.sv]
module bftr_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bftr_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [bftr_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [bftr_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [bftr_pkg::PIX_BITS-1:0]       origin_x,
    output logic [bftr_pkg::PIX_BITS-1:0]       origin_y,
    output logic [bftr_pkg::COLOR_BITS-1:0]     text_color
);
    import bftr_pkg::*;

    localparam int IDX_BITS = CFG_ADDR_BITS - 2;
    localparam logic [IDX_BITS-1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_TEXT_COLOR = 2'd2;

    logic [IDX_BITS-1:0]   idx;
    logic                  wr_en;
    logic [PIX_BITS-1:0]   origin_x_reg, origin_x_next;
    logic [PIX_BITS-1:0]   origin_y_reg, origin_y_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;

    assign idx    = paddr[CFG_ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        color_next    = color_reg;
        if (wr_en) begin
            case (idx)
                REG_ORIGIN_X:   origin_x_next = pwdata[PIX_BITS-1:0];
                REG_ORIGIN_Y:   origin_y_next = pwdata[PIX_BITS-1:0];
                REG_TEXT_COLOR: color_next    = pwdata[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            color_reg    <= '1;
        end else begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            color_reg    <= color_next;
        end
    end

    always_comb begin
        case (idx)
            REG_ORIGIN_X:   prdata = CFG_DATA_BITS'(origin_x_reg);
            REG_ORIGIN_Y:   prdata = CFG_DATA_BITS'(origin_y_reg);
            REG_TEXT_COLOR: prdata = CFG_DATA_BITS'(color_reg);
            default:        prdata = '0;
        endcase
    end

    assign origin_x   = origin_x_reg;
    assign origin_y   = origin_y_reg;
    assign text_color = color_reg;

endmodule

[rtl/bftr_ctrl.sv]
module bftr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  bftr_pkg::dp_status_t   status,
    output bftr_pkg::dp_cmd_t      cmd
);
    import bftr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        cmd.op        = CMD_IDLE;
        cmd.emit      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (status.code_newline) begin
                        cmd.op = CMD_NEWLINE;
                    end else if (status.code_glyph) begin
                        cmd.op        = CMD_LOAD;
                        state_next    = ST_SCAN;
                        s_tready_next = 1'b0;
                    end else begin
                        cmd.op = CMD_SKIP;
                    end
                end
            end
            ST_SCAN: begin
                if (!status.cell_lit) begin
                    cmd.op = CMD_STEP;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.cell_last) begin
                        cmd.op        = CMD_DONE;
                        state_next    = ST_IDLE;
                        s_tready_next = 1'b1;
                    end else begin
                        cmd.op = CMD_STEP;
                    end
                end
            end
            default: begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_tready = s_tready_reg;

endmodule

[rtl/bftr_datapath.sv]
module bftr_datapath #(
    parameter int COORD_BITS = bftr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bftr_pkg::dp_cmd_t                 cmd,
    output bftr_pkg::dp_status_t              status,
    input  logic [bftr_pkg::CHAR_BITS-1:0]    s_char_code,
    input  logic                              s_string_start,
    input  logic [bftr_pkg::PIX_BITS-1:0]     origin_x,
    input  logic [bftr_pkg::PIX_BITS-1:0]     origin_y,
    input  logic [bftr_pkg::COLOR_BITS-1:0]   text_color,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [bftr_pkg::PIX_BITS-1:0]     m_pixel_x,
    output logic [bftr_pkg::PIX_BITS-1:0]     m_pixel_y,
    output logic [bftr_pkg::COLOR_BITS-1:0]   m_pixel_color,
    output logic                              m_last_pixel
);
    import bftr_pkg::*;

    localparam int SW  = (COORD_BITS > PIX_BITS ? COORD_BITS : PIX_BITS) + 1;
    localparam int CW1 = COORD_BITS + 1;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [SW-1:0] PIX_MAX =
        (COORD_BITS < PIX_BITS) ? SW'(COORD_MAX) : SW'({PIX_BITS{1'b1}});

    function automatic logic [COORD_BITS-1:0] clamp_origin(input logic [PIX_BITS-1:0] o);
        logic [SW-1:0] w;
        w = SW'(o);
        return (w > SW'(COORD_MAX)) ? COORD_MAX : w[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] sat_adv(input logic [COORD_BITS-1:0] c,
                                                     input logic [3:0] inc);
        logic [CW1-1:0] s;
        s = {1'b0, c} + CW1'(inc);
        return s[COORD_BITS] ? COORD_MAX : s[COORD_BITS-1:0];
    endfunction

    function automatic logic [PIX_BITS-1:0] pix_sat(input logic [COORD_BITS-1:0] c,
                                                   input logic [ROW_BITS-1:0] off);
        logic [SW-1:0] s;
        logic [SW-1:0] p;
        s = SW'(c) + SW'(off);
        p = (s > PIX_MAX) ? PIX_MAX : s;
        return p[PIX_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0]  cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0]  cursor_y_reg, cursor_y_next;
    logic [GLYPH_CELLS-1:0] bitmap_reg, bitmap_next;
    logic [CELL_BITS-1:0]   cell_reg, cell_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [PIX_BITS-1:0]    pix_x_reg, pix_x_next;
    logic [PIX_BITS-1:0]    pix_y_reg, pix_y_next;
    logic [COLOR_BITS-1:0]  color_reg, color_next;
    logic                   last_reg, last_next;

    logic [COORD_BITS-1:0]  base_x, base_y;
    logic [SLOT_BITS:0]     lookup;
    logic [GLYPH_CELLS-1:0] rest;

    assign base_x = s_string_start ? clamp_origin(origin_x) : cursor_x_reg;
    assign base_y = s_string_start ? clamp_origin(origin_y) : cursor_y_reg;
    assign lookup = glyph_lookup(s_char_code);
    assign rest   = (bitmap_reg >> cell_reg) >> 1;

    assign status.code_newline = (s_char_code == CHAR_NEWLINE);
    assign status.code_glyph   = lookup[SLOT_BITS];
    assign status.cell_lit     = bitmap_reg[cell_reg];
    assign status.cell_last    = (rest == '0);
    assign status.out_free     = !m_tvalid_reg || m_tready;

    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        bitmap_next   = bitmap_reg;
        cell_next     = cell_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        case (cmd.op)
            CMD_NEWLINE: begin
                cursor_x_next = clamp_origin(origin_x);
                cursor_y_next = sat_adv(base_y, 4'(ADV_Y));
            end
            CMD_SKIP: begin
                cursor_x_next = sat_adv(base_x, 4'(ADV_X));
                cursor_y_next = base_y;
            end
            CMD_LOAD: begin
                cursor_x_next = base_x;
                cursor_y_next = base_y;
                bitmap_next   = glyph_bitmap(lookup[SLOT_BITS-1:0]);
                cell_next     = '0;
                row_next      = '0;
                col_next      = '0;
            end
            CMD_STEP: begin
                cell_next = cell_reg + 1'b1;
                if (col_reg == COL_BITS'(GLYPH_W - 1)) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            CMD_DONE: begin
                cursor_x_next = sat_adv(cursor_x_reg, 4'(ADV_X));
            end
            default: ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        pix_x_next    = pix_x_reg;
        pix_y_next    = pix_y_reg;
        color_next    = color_reg;
        last_next     = last_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            pix_x_next    = pix_sat(cursor_x_reg, ROW_BITS'(col_reg));
            pix_y_next    = pix_sat(cursor_y_reg, row_reg);
            color_next    = text_color;
            last_next     = (cmd.op == CMD_DONE);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            cell_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            cell_reg     <= cell_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bitmap_reg <= bitmap_next;
        pix_x_reg  <= pix_x_next;
        pix_y_reg  <= pix_y_next;
        color_reg  <= color_next;
        last_reg   <= last_next;
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_pixel_x     = pix_x_reg;
    assign m_pixel_y     = pix_y_reg;
    assign m_pixel_color = color_reg;
    assign m_last_pixel  = last_reg;

endmodule

[rtl/bitmap_font_text_rasterizer_unit.sv]
// Channel  | Dir | Handshake                 | Payload
// s_       | in  | s_tvalid / s_tready       | tdata: char_code, tuser: string_start
// m_       | out | m_tvalid / m_tready       | tdata: pixel_x, pixel_y, pixel_color;
//          |     |                           | tlast: last_pixel
// cfg      | in  | psel / penable / pready   | origin_x @0x0, origin_y @0x4, text_color @0x8
//
// Newline, space and unknown codes are consumed while the controller stays idle.
// A glyph is loaded, then the single-cell glyph scanner steps up to its last lit cell.
// A lit cell waits while the output register is full and m_tready is low.
// Synchronous active-low reset clears cursor, scanner and output valid.
`include "bitmap_font_text_rasterizer_unit_assert.svh"

module bitmap_font_text_rasterizer_unit #(
    parameter int COORD_BITS = bftr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bftr_pkg::CHAR_BITS-1:0]       s_tdata,   // [7:0] char_code
    input  logic                                 s_tuser,   // [0] string_start
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] pixel_x, [31:16] pixel_y, [55:32] pixel_color
    output logic [bftr_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    output logic                                 m_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bftr_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [bftr_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [bftr_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import bftr_pkg::*;

    logic [PIX_BITS-1:0]   origin_x;
    logic [PIX_BITS-1:0]   origin_y;
    logic [COLOR_BITS-1:0] text_color;
    logic [PIX_BITS-1:0]   pixel_x;
    logic [PIX_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    dp_cmd_t               cmd;
    dp_status_t            status;

    bftr_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .text_color (text_color)
    );

    bftr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bftr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_char_code    (s_tdata),
        .s_string_start (s_tuser),
        .origin_x       (origin_x),
        .origin_y       (origin_y),
        .text_color     (text_color),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_pixel_x      (pixel_x),
        .m_pixel_y      (pixel_y),
        .m_pixel_color  (pixel_color),
        .m_last_pixel   (m_tlast)
    );

    assign m_tdata = {pixel_color, pixel_y, pixel_x};

    `BFTR_ASSERT_SAME(a_emit_needs_room, cmd.emit, (!m_tvalid || m_tready), "pixel emitted into a full output register")
    `BFTR_ASSERT_SAME(a_scan_blocks_input, (cmd.op == CMD_STEP || cmd.op == CMD_DONE), !s_tready, "input open during glyph scan")
    `BFTR_ASSERT_NEXT(a_load_closes_input, (s_tvalid && s_tready && cmd.op == CMD_LOAD), !s_tready, "input still open after glyph load")

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

localparam int FONT_COLS        = 5;
localparam int FONT_ROWS        = 7;
localparam int FONT_CELLS       = FONT_COLS * FONT_ROWS;
localparam int STEP_X           = FONT_COLS + 2;
localparam int STEP_Y           = FONT_ROWS + 1;
localparam int FIRST_DIGIT_SLOT = 26;
localparam int COLON_SLOT       = 36;
localparam int PERIOD_SLOT      = 37;
localparam int REPORT_LIMIT     = 10;

localparam logic [3:0] REG_ORIGIN_X   = 4'h0;
localparam logic [3:0] REG_ORIGIN_Y   = 4'h4;
localparam logic [3:0] REG_TEXT_COLOR = 4'h8;
localparam logic [3:0] REG_UNUSED     = 4'hC;

localparam logic [7:0] CHAR_SPACE = 8'h20;

typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [23:0] color;
    logic        last;
} pixel_t;

class glyph_raster_model;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [23:0] text_color;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    pixel_t      pending_pixels[$];
    int unsigned mismatches;
    int unsigned pixels_checked;
    int unsigned glyphs_drawn;
    int unsigned chars_drawn;

    function new();
        origin_x       = '0;
        origin_y       = '0;
        text_color     = 24'hFFFFFF;
        cursor_x       = '0;
        cursor_y       = '0;
        mismatches     = 0;
        pixels_checked = 0;
        glyphs_drawn   = 0;
        chars_drawn    = 0;
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function void write_reg(logic [3:0] addr, logic [31:0] value);
        case (addr)
            REG_ORIGIN_X: begin
                origin_x = value[15:0];
            end
            REG_ORIGIN_Y: begin
                origin_y = value[15:0];
            end
            REG_TEXT_COLOR: begin
                text_color = value[23:0];
            end
            default: begin
            end
        endcase
    endfunction

    function logic [31:0] reg_value(logic [3:0] addr);
        case (addr)
            REG_ORIGIN_X: begin
                return {16'h0, origin_x};
            end
            REG_ORIGIN_Y: begin
                return {16'h0, origin_y};
            end
            REG_TEXT_COLOR: begin
                return {8'h0, text_color};
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    function void check_register(logic [3:0] addr, logic [31:0] got);
        if (got !== reg_value(addr)) begin
            report($sformatf("register 0x%0h readback: expected %08h, got %08h",
                             addr, reg_value(addr), got));
        end
    endfunction

    function logic [15:0] sat_add(logic [15:0] a, int unsigned b);
        logic [16:0] sum;
        sum = {1'b0, a} + 17'(b);
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function int glyph_slot(logic [7:0] code);
        if (code >= bftr_pkg::CHAR_UPPER_A && code <= bftr_pkg::CHAR_UPPER_Z) begin
            return int'(code - bftr_pkg::CHAR_UPPER_A);
        end
        if (code >= bftr_pkg::CHAR_DIGIT_0 && code <= bftr_pkg::CHAR_DIGIT_9) begin
            return FIRST_DIGIT_SLOT + int'(code - bftr_pkg::CHAR_DIGIT_0);
        end
        if (code == bftr_pkg::CHAR_COLON) begin
            return COLON_SLOT;
        end
        if (code == bftr_pkg::CHAR_PERIOD) begin
            return PERIOD_SLOT;
        end
        return -1;
    endfunction

    // top row in the highest bits, leftmost column first within a row
    function logic [FONT_CELLS-1:0] glyph_cells(int slot);
        case (slot)
            0:  return {5'h1F, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            1:  return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            2:  return {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            3:  return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            4:  return {5'h1F, 5'h10, 5'h10, 5'h1F, 5'h10, 5'h10, 5'h1F};
            5:  return {5'h1F, 5'h10, 5'h10, 5'h1F, 5'h10, 5'h10, 5'h10};
            6:  return {5'h1F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h1F};
            7:  return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            8:  return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            9:  return {5'h1F, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
            10: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            11: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            12: return {5'h1F, 5'h15, 5'h15, 5'h15, 5'h15, 5'h11, 5'h11};
            13: return {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11};
            14: return {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
            15: return {5'h1F, 5'h11, 5'h11, 5'h1F, 5'h10, 5'h10, 5'h10};
            16: return {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h01};
            17: return {5'h1F, 5'h11, 5'h11, 5'h1F, 5'h14, 5'h12, 5'h11};
            18: return {5'h1F, 5'h10, 5'h10, 5'h1F, 5'h01, 5'h01, 5'h1F};
            19: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            20: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F};
            21: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            22: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h1F};
            23: return {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11};
            24: return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h04, 5'h04, 5'h04};
            25: return {5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h1F};
            26: return {5'h1F, 5'h19, 5'h15, 5'h15, 5'h15, 5'h13, 5'h1F};
            27: return {5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            28: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h0C, 5'h10, 5'h1F};
            29: return {5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E};
            30: return {5'h03, 5'h09, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01};
            31: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            32: return {5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            33: return {5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h10};
            34: return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            35: return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E};
            36: return {5'h04, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h04};
            37: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h18, 5'h18};
            default: return '0;
        endcase
    endfunction

    function void draw_char(logic [7:0] code, logic start);
        int                    slot;
        int                    lit;
        logic [FONT_CELLS-1:0] cells;
        pixel_t                px;
        chars_drawn++;
        if (start) begin
            cursor_x = origin_x;
            cursor_y = origin_y;
        end
        if (code == bftr_pkg::CHAR_NEWLINE) begin
            cursor_x = origin_x;
            cursor_y = sat_add(cursor_y, STEP_Y);
            return;
        end
        slot = glyph_slot(code);
        if (slot >= 0) begin
            cells = glyph_cells(slot);
            lit   = 0;
            for (int r = 0; r < FONT_ROWS; r++) begin
                for (int c = 0; c < FONT_COLS; c++) begin
                    if (cells[FONT_CELLS - 1 - FONT_COLS * r - c]) begin
                        px.x     = sat_add(cursor_x, c);
                        px.y     = sat_add(cursor_y, r);
                        px.color = text_color;
                        px.last  = 1'b0;
                        pending_pixels.push_back(px);
                        lit++;
                    end
                end
            end
            if (lit > 0) begin
                pending_pixels[pending_pixels.size() - 1].last = 1'b1;
            end
            glyphs_drawn++;
        end
        cursor_x = sat_add(cursor_x, STEP_X);
    endfunction

    function void compare_pixel(pixel_t got);
        pixel_t want;
        if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                             got.x, got.y, got.color, got.last));
            return;
        end
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
            got.last !== want.last) begin
            report({$sformatf("pixel mismatch: expected x=%0d y=%0d color=%06h last=%0b,",
                              want.x, want.y, want.color, want.last),
                    $sformatf(" got x=%0d y=%0d color=%06h last=%0b",
                              got.x, got.y, got.color, got.last)});
        end
    endfunction

    function void flush_leftovers();
        if (pending_pixels.size() != 0) begin
            report($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
            pending_pixels.delete();
        end
    endfunction
endclass

module tb;

    localparam int ITEMS_PER_PHASE = 60;
    localparam int RANDOM_PHASES   = 6;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LONG_HOLD       = 400;
    localparam int STALL_LIMIT     = 3000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glyph_raster_model model = new();

    int quiet_cycles      = 0;
    int burst_left        = 0;
    int long_hold_request = 0;
    int long_holds_done   = 0;
    int settings_used     = 0;

    bitmap_font_text_rasterizer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            model.compare_pixel({m_tdata[15:0], m_tdata[31:16], m_tdata[55:32], m_tlast});
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: stall patterns of its own, plus one long hold-off on request
    initial begin
        int mode;
        int len;
        m_tready = 1'b0;
        forever begin
            if (long_hold_request != 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_request = 0;
                long_holds_done++;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(8, 60);
                repeat (len) begin
                    @(negedge aclk);
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    task automatic offer_char(input logic [7:0] code, input logic start);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom_range(0, 255));
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        model.draw_char(code, start);
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        while (model.pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic [3:0] addr, input logic write,
                              input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (write) begin
            model.write_reg(addr, value);
        end else begin
            model.check_register(addr, prdata);
        end
    endtask

    task automatic apply_settings(input logic [15:0] ox, input logic [15:0] oy,
                                  input logic [23:0] color);
        apb_access(REG_ORIGIN_X, 1'b1, {16'h0, ox});
        apb_access(REG_ORIGIN_Y, 1'b1, {16'h0, oy});
        apb_access(REG_TEXT_COLOR, 1'b1, {8'h0, color});
        apb_access(REG_ORIGIN_X, 1'b0, '0);
        apb_access(REG_ORIGIN_Y, 1'b0, '0);
        apb_access(REG_TEXT_COLOR, 1'b0, '0);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        int g;
        r = $urandom_range(0, 99);
        g = $urandom_range(0, PERIOD_SLOT);
        if (r < 72) begin
            if (g < FIRST_DIGIT_SLOT) begin
                return bftr_pkg::CHAR_UPPER_A + 8'(g);
            end
            if (g < COLON_SLOT) begin
                return bftr_pkg::CHAR_DIGIT_0 + 8'(g - FIRST_DIGIT_SLOT);
            end
            return (g == COLON_SLOT) ? bftr_pkg::CHAR_COLON : bftr_pkg::CHAR_PERIOD;
        end
        if (r < 80) begin
            return bftr_pkg::CHAR_NEWLINE;
        end
        if (r < 88) begin
            return CHAR_SPACE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int sent;
        int len;
        logic first_start;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // reset values of origin and color
        offer_char("A", 1'b1);
        offer_char("8", 1'b0);
        offer_char("W", 1'b0);
        offer_char("Q", 1'b0);
        offer_char(".", 1'b0);
        offer_char(":", 1'b0);
        offer_char("0", 1'b0);
        offer_char("9", 1'b0);
        offer_char("Z", 1'b0);
        offer_char(CHAR_SPACE, 1'b0);
        offer_char(8'h00, 1'b0);
        offer_char(8'hFF, 1'b0);
        offer_char(bftr_pkg::CHAR_NEWLINE, 1'b0);
        offer_char("a", 1'b0);
        offer_char("M", 1'b0);
        offer_char(bftr_pkg::CHAR_NEWLINE, 1'b1);
        offer_char("I", 1'b0);
        release_input();
        wait_drained();

        // cursor near the top of the coordinate range
        apb_access(REG_UNUSED, 1'b1, 32'hFFFF_FFFF);
        apply_settings(16'hFFFA, 16'hFFF6, 24'h000000);
        offer_char("M", 1'b1);
        offer_char("N", 1'b0);
        offer_char("H", 1'b0);
        offer_char(bftr_pkg::CHAR_NEWLINE, 1'b0);
        offer_char("X", 1'b0);
        offer_char(bftr_pkg::CHAR_NEWLINE, 1'b0);
        offer_char("E", 1'b0);
        offer_char(CHAR_SPACE, 1'b1);
        release_input();
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_settings(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                                  24'($urandom_range(0, 24'hFFFFFF)));
                1: apply_settings(16'hFFFF, 16'hFFFF, 24'h000000);
                2: apply_settings(16'(16'hFFFF - $urandom_range(0, 20)), 16'hFFF0,
                                  24'($urandom_range(0, 24'hFFFFFF)));
                3: apply_settings(16'h0000, 16'hFFFF, 24'hFFFFFF);
                4: apply_settings(16'($urandom_range(0, 16'hFFFF)),
                                  16'($urandom_range(0, 16'hFFFF)),
                                  24'($urandom_range(0, 24'hFFFFFF)));
                default: apply_settings(16'h0000, 16'h0000, 24'h800001);
            endcase
            if (p == 0) begin
                long_hold_request = 1;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                len         = $urandom_range(1, 20);
                first_start = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < len; k++) begin
                    offer_char(pick_char(),
                               (k == 0) ? first_start : ($urandom_range(0, 29) == 0));
                end
                sent += len;
            end
            release_input();
            wait_drained();
        end

        model.flush_leftovers();
        $display("Run covered %0d characters (%0d glyphs, %0d pixels checked)",
                 model.chars_drawn, model.glyphs_drawn, model.pixels_checked);
        $display("over %0d settings, receiver long hold-offs: %0d, mismatches: %0d",
                 settings_used + 1, long_holds_done, model.mismatches);
        if (model.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[bitmap_font_text_rasterizer_unit.f]
+incdir+rtl
rtl/bftr_pkg.sv
rtl/bftr_regs.sv
rtl/bftr_ctrl.sv
rtl/bftr_datapath.sv
rtl/bitmap_font_text_rasterizer_unit.sv
test/tb.sv
